FILE: hw/rtl/sexpr_token_scanner_defines.svh
// ----------------------------------------------------------------------------
// sexpr_token_scanner_defines
// assertion macros shared by the s-expression scanner modules
// ----------------------------------------------------------------------------
`ifndef SEXPR_TOKEN_SCANNER_DEFINES_SVH
`define SEXPR_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define STS_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sexpr scanner check failed");

// next-cycle implication, clocked on clk, off during rst
`define STS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sexpr scanner check failed");

`endif

FILE: hw/rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// types and constants of the s-expression token scanner
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int SYMBOL_BYTES = 7;
  localparam int SYM_W        = 8 * SYMBOL_BYTES;
  localparam int COUNT_W      = $clog2(SYMBOL_BYTES + 1);
  localparam int LEN_W        = 3;
  localparam int NUM_W        = 31;
  localparam int MAX_TOKENS   = 3;
  localparam int SLOT_W       = $clog2(MAX_TOKENS);
  localparam int CNT_W        = $clog2(MAX_TOKENS + 1);

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  typedef enum logic [2:0] {
    KIND_LPAREN = 3'd0,
    KIND_RPAREN = 3'd1,
    KIND_INT    = 3'd2,
    KIND_CHAR   = 3'd3,
    KIND_SYM    = 3'd4,
    KIND_END    = 3'd5
  } token_kind_t;

  // tokens caused by one byte; each data kind appears at most once
  typedef struct packed {
    token_kind_t [MAX_TOKENS-1:0] kind;
    logic [CNT_W-1:0]             cnt;
    logic [NUM_W-1:0]             num;
    logic [7:0]                   chr;
    logic [SYM_W-1:0]             sym;
    logic [LEN_W-1:0]             len;
  } token_group_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sexpr_token_scanner.sv
// ----------------------------------------------------------------------------
// sexpr_token_scanner
// lexer for s-expression source text, one byte per transfer in, one token out
// ----------------------------------------------------------------------------
// The scanner takes one source byte per transfer and emits parenthesis,
// integer (saturating at 2147483647), character literal, symbol (first seven
// bytes kept) and end tokens; a byte can cause up to three tokens, the last
// one marked by last_of_run. A byte is registered on input and decoded
// against the scan state in the next cycle, and its tokens are loaded into
// the result register, from which they go out. Bytes are taken one per
// cycle as long as each causes at most one token and the output is not
// stalled; the result register hands out one token per cycle while the
// output is not stalled, so a byte that causes several tokens holds it until
// its last one is taken; a byte that causes none passes without using it.
// ----------------------------------------------------------------------------
`default_nettype none

module sexpr_token_scanner (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // source byte channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   text_byte,
  input  wire logic                         end_of_text,
  // token channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        token_kind,
  output logic [sts_pkg::NUM_W-1:0]         number_value,
  output logic [7:0]                        char_value,
  output logic [sts_pkg::SYM_W-1:0]         symbol_text,
  output logic [sts_pkg::LEN_W-1:0]         symbol_length,
  output logic                              last_of_run
);
  import sts_pkg::*;

  // tokens of the byte in decode, and the result register's room for them
  token_group_t grp;
  logic         grp_load;
  logic         grp_ready;

  // byte register, scan mode and accumulators, token decode
  sts_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .grp_ready   (grp_ready),
    .grp_load    (grp_load),
    .grp         (grp)
  );

  // result register, drains one token per transfer
  sts_token_buf u_token_buf (
    .clk           (clk),
    .rst           (rst),
    .grp_load      (grp_load),
    .grp_in        (grp),
    .grp_ready     (grp_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_kind    (token_kind),
    .number_value  (number_value),
    .char_value    (char_value),
    .symbol_text   (symbol_text),
    .symbol_length (symbol_length),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/sts_scan.sv
// ----------------------------------------------------------------------------
// sts_scan
// input byte register, scan state and token decode for one byte
// ----------------------------------------------------------------------------
`default_nettype none

`include "sexpr_token_scanner_defines.svh"

module sts_scan (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          text_byte,
  input  wire logic                end_of_text,
  input  wire logic                grp_ready,
  output logic                     grp_load,
  output sts_pkg::token_group_t    grp
);
  import sts_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam int         RADIX     = 10;
  localparam int         PROD_W    = NUM_W + 4;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_CHAR,
    MODE_SYM
  } mode_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic is_graph(input logic [7:0] c);
    return (c >= 8'h21) && (c <= 8'h7e);
  endfunction

  logic               q_valid;
  logic [7:0]         q_byte;
  logic               q_eot;
  mode_t              mode, mode_next;
  logic [NUM_W-1:0]   accum, accum_next;
  logic [7:0]         lit, lit_next;
  logic [SYM_W-1:0]   store, store_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               adv;
  logic [PROD_W-1:0]  prod;
  logic [3:0]         digit;
  token_group_t       g;

  assign digit = 4'(q_byte - CH_ZERO);
  assign prod  = PROD_W'(accum) * PROD_W'(RADIX) + PROD_W'(digit);

  always_comb begin
    logic             idle_proc;
    logic [CNT_W-1:0] n;
    mode_next  = mode;
    accum_next = accum;
    lit_next   = lit;
    store_next = store;
    count_next = count;
    g          = '0;
    n          = '0;
    idle_proc  = 1'b0;

    case (mode)
      MODE_INT: begin
        if (is_digit(q_byte)) begin
          accum_next = (prod > PROD_W'(NUM_MAX)) ? NUM_MAX : prod[NUM_W-1:0];
        end else begin
          g.kind[SLOT_W'(n)] = KIND_INT;
          g.num              = accum;
          n                  = n + CNT_W'(1);
          mode_next          = MODE_IDLE;
          accum_next         = '0;
          idle_proc          = 1'b1;
        end
      end
      MODE_CHAR: begin
        if (q_byte == CH_QUOTE) begin
          g.kind[SLOT_W'(n)] = KIND_CHAR;
          g.chr              = lit;
          n                  = n + CNT_W'(1);
          mode_next          = MODE_IDLE;
          lit_next           = '0;
        end else begin
          lit_next = q_byte;
        end
      end
      MODE_SYM: begin
        if (q_byte == CH_NUL || q_byte == CH_LPAREN || q_byte == CH_RPAREN ||
            is_space(q_byte)) begin
          g.kind[SLOT_W'(n)] = KIND_SYM;
          g.sym              = store;
          g.len              = LEN_W'(count);
          n                  = n + CNT_W'(1);
          mode_next          = MODE_IDLE;
          store_next         = '0;
          count_next         = '0;
          idle_proc          = 1'b1;
        end else if (is_graph(q_byte) && count < COUNT_W'(SYMBOL_BYTES)) begin
          for (int i = 0; i < SYMBOL_BYTES; i++) begin
            if (COUNT_W'(i) == count) store_next[8*i +: 8] = q_byte;
          end
          count_next = count + COUNT_W'(1);
        end
      end
      default: idle_proc = 1'b1;
    endcase

    // between tokens: start a token or emit a parenthesis
    if (idle_proc) begin
      if (is_digit(q_byte)) begin
        mode_next  = MODE_INT;
        accum_next = NUM_W'(digit);
      end else if (q_byte == CH_QUOTE) begin
        mode_next = MODE_CHAR;
        lit_next  = '0;
      end else if (q_byte == CH_LPAREN) begin
        g.kind[SLOT_W'(n)] = KIND_LPAREN;
        n                  = n + CNT_W'(1);
      end else if (q_byte == CH_RPAREN) begin
        g.kind[SLOT_W'(n)] = KIND_RPAREN;
        n                  = n + CNT_W'(1);
      end else if (is_graph(q_byte)) begin
        mode_next  = MODE_SYM;
        store_next = SYM_W'(q_byte);
        count_next = COUNT_W'(1);
      end
    end

    // end of text: flush a pending integer or symbol, drop a literal
    if (q_eot) begin
      if (mode_next == MODE_INT) begin
        g.kind[SLOT_W'(n)] = KIND_INT;
        g.num              = accum_next;
        n                  = n + CNT_W'(1);
      end else if (mode_next == MODE_SYM) begin
        g.kind[SLOT_W'(n)] = KIND_SYM;
        g.sym              = store_next;
        g.len              = LEN_W'(count_next);
        n                  = n + CNT_W'(1);
      end
      g.kind[SLOT_W'(n)] = KIND_END;
      n                  = n + CNT_W'(1);
      mode_next          = MODE_IDLE;
      accum_next         = '0;
      lit_next           = '0;
      store_next         = '0;
      count_next         = '0;
    end
    g.cnt = n;
  end

  assign adv      = q_valid && (g.cnt == '0 || grp_ready);
  assign in_stall = q_valid && !adv;
  assign grp_load = adv && (g.cnt != '0);
  assign grp      = g;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      mode    <= MODE_IDLE;
      accum   <= '0;
      lit     <= '0;
      store   <= '0;
      count   <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        q_valid <= 1'b1;
        q_byte  <= text_byte;
        q_eot   <= end_of_text;
      end else if (adv) begin
        q_valid <= 1'b0;
      end
      if (adv) begin
        mode  <= mode_next;
        accum <= accum_next;
        lit   <= lit_next;
        store <= store_next;
        count <= count_next;
      end
    end
  end

  `STS_ASSERT_IMPLY(a_idle_clear, mode == MODE_IDLE,
    accum == '0 && lit == '0 && store == '0 && count == '0)
  `STS_ASSERT_NEXT(a_eot_idle, adv && q_eot, mode == MODE_IDLE)
  `STS_ASSERT_NEXT(a_byte_held, q_valid && !adv, q_valid && $stable(q_byte))

endmodule

`default_nettype wire

FILE: hw/rtl/sts_token_buf.sv
// ----------------------------------------------------------------------------
// sts_token_buf
// result register: holds the tokens of one byte and hands them out in order
// ----------------------------------------------------------------------------
`default_nettype none

`include "sexpr_token_scanner_defines.svh"

module sts_token_buf (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              grp_load,
  input  wire sts_pkg::token_group_t             grp_in,
  output logic                                   grp_ready,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [2:0]                             token_kind,
  output logic [sts_pkg::NUM_W-1:0]              number_value,
  output logic [7:0]                             char_value,
  output logic [sts_pkg::SYM_W-1:0]              symbol_text,
  output logic [sts_pkg::LEN_W-1:0]              symbol_length,
  output logic                                   last_of_run
);
  import sts_pkg::*;

  token_group_t      grp;
  logic              grp_valid;
  logic [SLOT_W-1:0] idx;
  logic              last, take;
  token_kind_t       kind;

  assign kind      = grp.kind[idx];
  assign last      = CNT_W'(idx) == (grp.cnt - CNT_W'(1));
  assign take      = grp_valid && !out_stall;
  assign grp_ready = !grp_valid || (take && last);

  assign out_valid     = grp_valid;
  assign token_kind    = kind;
  assign number_value  = (kind == KIND_INT)  ? grp.num : '0;
  assign char_value    = (kind == KIND_CHAR) ? grp.chr : '0;
  assign symbol_text   = (kind == KIND_SYM)  ? grp.sym : '0;
  assign symbol_length = (kind == KIND_SYM)  ? grp.len : '0;
  assign last_of_run   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= '0;
    end else if (grp_load) begin
      grp       <= grp_in;
      grp_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (last) begin
        grp_valid <= 1'b0;
      end else begin
        idx <= idx + SLOT_W'(1);
      end
    end
  end

  `STS_ASSERT_IMPLY(a_idx_in_range, grp_valid,
    grp.cnt != '0 && CNT_W'(idx) < grp.cnt)
  `STS_ASSERT_NEXT(a_stall_holds, grp_valid && out_stall,
    grp_valid && $stable(idx))
  `STS_ASSERT_IMPLY(a_load_room, grp_load, grp_ready)

endmodule

`default_nettype wire

FILE: tb/sexpr_token_scanner_tb.sv
// ----------------------------------------------------------------------------
// sexpr_token_scanner testbench
// checks the token stream of the s-expression scanner against a local model
// ----------------------------------------------------------------------------
// Source bytes go in through the valid/stall byte channel. Each accepted byte
// runs through a scan-state model kept in this file, which queues the tokens
// that byte should cause. Every token the scanner hands out is compared
// field by field with the oldest queued token. A short directed part covers
// saturation, symbol truncation, literals and text ends; random texts of
// well-formed tokens, plain noise and a back-to-back stretch follow. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sts_pkg::*;

  // byte values the scanner treats specially
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer
  localparam int SETTLE_CYCLES = 8;     // byte-to-token latency plus margin
  localparam int GROWN_W       = NUM_W + 5;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_INT,
    SCAN_CHAR,
    SCAN_SYM
  } scan_mode_t;

  // one token as it should leave the scanner
  typedef struct packed {
    token_kind_t      kind;
    logic [NUM_W-1:0] num;
    logic [7:0]       chr;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    logic             last;
  } token_t;

  logic             clk;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [7:0]       text_byte   = 8'h00;
  logic             end_of_text = 1'b0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic [2:0]       token_kind;
  logic [NUM_W-1:0] number_value;
  logic [7:0]       char_value;
  logic [SYM_W-1:0] symbol_text;
  logic [LEN_W-1:0] symbol_length;
  logic             last_of_run;

  // model of the scan state
  scan_mode_t       scan_mode = SCAN_IDLE;
  logic [NUM_W-1:0] num_acc   = '0;
  logic [7:0]       lit_byte  = '0;
  logic [SYM_W-1:0] sym_bytes = '0;
  logic [2:0]       sym_count = '0;

  token_t     tokens_due[$];   // tokens owed by bytes already transferred
  logic [7:0] text_q[$];       // source text being built for the next send
  int         errors     = 0;
  int         items_sent = 0;
  int         quiet_cycles = 0;
  int         stall_run  = 0;
  bit         gaps_on    = 1'b1;
  bit         stall_on   = 1'b1;

  sexpr_token_scanner u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .number_value (number_value),
    .char_value   (char_value),
    .symbol_text  (symbol_text),
    .symbol_length(symbol_length),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // printable and not a space
  function automatic bit is_graph(input logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7E;
  endfunction

  function automatic token_t make_token(input token_kind_t kind,
                                        input logic [NUM_W-1:0] num,
                                        input logic [7:0] chr,
                                        input logic [SYM_W-1:0] sym,
                                        input logic [LEN_W-1:0] len);
    token_t t;
    t.kind = kind;
    t.num  = num;
    t.chr  = chr;
    t.sym  = sym;
    t.len  = len;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic void clear_scan();
    scan_mode = SCAN_IDLE;
    num_acc   = '0;
    lit_byte  = '0;
    sym_bytes = '0;
    sym_count = '0;
  endfunction

  // bytes past the seventh are dropped
  function automatic void keep_symbol_byte(input logic [7:0] c);
    if (sym_count < SYMBOL_BYTES) begin
      sym_bytes[8*sym_count +: 8] = c;
      sym_count++;
    end
  endfunction

  // advance the scan state by one byte and queue the tokens it causes
  function automatic void predict_tokens(input logic [7:0] c, input logic eot);
    token_t             run[$];
    logic [GROWN_W-1:0] grown;
    bit                 from_idle;
    from_idle = 1'b1;
    case (scan_mode)
      SCAN_INT: begin
        if (is_digit(c)) begin
          grown = GROWN_W'(num_acc) * GROWN_W'(10) + GROWN_W'(c - CH_ZERO);
          num_acc = (grown > GROWN_W'(NUM_MAX)) ? NUM_MAX : grown[NUM_W-1:0];
          from_idle = 1'b0;
        end else begin
          run.push_back(make_token(KIND_INT, num_acc, '0, '0, '0));
          clear_scan();
        end
      end
      SCAN_CHAR: begin
        // any byte but the quote replaces the held one
        if (c == CH_QUOTE) begin
          run.push_back(make_token(KIND_CHAR, '0, lit_byte, '0, '0));
          clear_scan();
        end else begin
          lit_byte = c;
        end
        from_idle = 1'b0;
      end
      SCAN_SYM: begin
        // the delimiter closes the symbol and is then scanned on its own
        if (c == CH_NUL || c == CH_LPAREN || c == CH_RPAREN || c == CH_SPACE ||
            (c >= 8'h09 && c <= 8'h0D)) begin
          run.push_back(make_token(KIND_SYM, '0, '0, sym_bytes, sym_count));
          clear_scan();
        end else begin
          if (is_graph(c)) keep_symbol_byte(c);
          from_idle = 1'b0;
        end
      end
      default: ;
    endcase
    if (from_idle) begin
      if (is_digit(c)) begin
        scan_mode = SCAN_INT;
        num_acc   = NUM_W'(c - CH_ZERO);
      end else if (c == CH_QUOTE) begin
        scan_mode = SCAN_CHAR;
        lit_byte  = '0;
      end else if (c == CH_LPAREN) begin
        run.push_back(make_token(KIND_LPAREN, '0, '0, '0, '0));
      end else if (c == CH_RPAREN) begin
        run.push_back(make_token(KIND_RPAREN, '0, '0, '0, '0));
      end else if (is_graph(c)) begin
        scan_mode = SCAN_SYM;
        sym_bytes = '0;
        sym_count = '0;
        keep_symbol_byte(c);
      end
    end
    // end of text flushes a pending number or symbol; an open literal is lost
    if (eot) begin
      if (scan_mode == SCAN_INT)
        run.push_back(make_token(KIND_INT, num_acc, '0, '0, '0));
      else if (scan_mode == SCAN_SYM)
        run.push_back(make_token(KIND_SYM, '0, '0, sym_bytes, sym_count));
      clear_scan();
      run.push_back(make_token(KIND_END, '0, '0, '0, '0));
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) tokens_due.push_back(run[i]);
  endfunction

  // ------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("ERROR at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    errors++;
  endtask

  // every token transfer is compared with the oldest owed token
  always @(posedge clk) begin : token_check
    token_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("token with none owed, kind", '0, 64'(token_kind));
      end else begin
        want = tokens_due.pop_front();
        if (token_kind !== want.kind)
          report_mismatch("token_kind", 64'(want.kind), 64'(token_kind));
        if (number_value !== want.num)
          report_mismatch("number_value", 64'(want.num), 64'(number_value));
        if (char_value !== want.chr)
          report_mismatch("char_value", 64'(want.chr), 64'(char_value));
        if (symbol_text !== want.sym)
          report_mismatch("symbol_text", 64'(want.sym), 64'(symbol_text));
        if (symbol_length !== want.len)
          report_mismatch("symbol_length", 64'(want.len), 64'(symbol_length));
        if (last_of_run !== want.last)
          report_mismatch("last_of_run", 64'(want.last), 64'(last_of_run));
      end
    end
  end

  // ends the run once nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------- stimulus

  // mostly no gap, often a short one, now and then a long one
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  // receiver stalls in runs, released in between
  always @(posedge clk) begin : stall_gen
    int n;
    if (rst || !stall_on) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 4);
    end else begin
      n = random_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        stall_run <= n - 1;
      end
    end
  end

  // one byte transfer; the model advances when the byte is taken
  task automatic send_byte(input logic [7:0] c, input logic eot);
    int gap;
    gap = gaps_on ? random_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= c;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    predict_tokens(c, eot);
    items_sent++;
  endtask

  task automatic send_string(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close && (i == s.len() - 1));
  endtask

  // sends the built text, optionally closing it with end_of_text
  task automatic send_text(input bit close);
    foreach (text_q[i])
      send_byte(text_q[i], close && (i == text_q.size() - 1));
  endtask

  // sender holds off until every owed token is out and the pipe is empty
  task automatic wait_tokens_drained();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // appends one random token, usually followed by whitespace
  function automatic void add_random_token();
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      text_q.push_back(CH_LPAREN);
    end else if (pick < 24) begin
      text_q.push_back(CH_RPAREN);
    end else if (pick < 42) begin
      // mostly short numbers, some long enough to saturate
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
      repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (pick < 54) begin
      // literal body of any byte but the quote, possibly empty
      text_q.push_back(CH_QUOTE);
      n = $urandom_range(0, 2);
      repeat (n) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
        text_q.push_back(c);
      end
      text_q.push_back(CH_QUOTE);
    end else if (pick < 78) begin
      // symbol, sometimes past seven bytes, with stray non-printing bytes
      do c = 8'($urandom_range(8'h21, 8'h7E));
      while (c == CH_LPAREN || c == CH_RPAREN || c == CH_QUOTE || is_digit(c));
      text_q.push_back(c);
      n = $urandom_range(0, 9);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) c = 8'($urandom_range(8'h7F, 8'hFF));
          else if ($urandom_range(0, 1) == 0) c = 8'($urandom_range(8'h01, 8'h08));
          else c = 8'($urandom_range(8'h0E, 8'h1F));
        end else begin
          do c = 8'($urandom_range(8'h21, 8'h7E));
          while (c == CH_LPAREN || c == CH_RPAREN);
        end
        text_q.push_back(c);
      end
    end else if (pick < 90) begin
      text_q.push_back(CH_NUL);
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0:       text_q.push_back(8'h09);
        1:       text_q.push_back(8'h0A);
        2:       text_q.push_back(8'h0B + 8'($urandom_range(0, 2)));
        default: text_q.push_back(CH_SPACE);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------- tests

  // ten nines overflow and saturate; the paren closes the number
  task automatic test_integer_overflow();
    send_string("9999999999(", 1'b0);
  endtask

  // 0xff inside is skipped, the eighth kept byte is dropped, and the closing
  // paren on the last byte gives three tokens at once
  task automatic test_long_symbol();
    send_string("ab", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_string("cdefgh)", 1'b1);
  endtask

  // literal bytes replace each other (nul wins), empty literal, literal left
  // open at the end of text, then a byte after the end starts a new text
  task automatic test_char_literals();
    send_byte(CH_QUOTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_string("''", 1'b0);
    send_byte(CH_QUOTE, 1'b1);
    send_string("7", 1'b1);
  endtask

  // random texts of well-formed tokens, most closed by end_of_text
  task automatic test_random_text(input int n_items);
    int first;
    int ntok;
    first = items_sent;
    while (items_sent - first < n_items) begin
      text_q.delete();
      ntok = $urandom_range(2, 10);
      repeat (ntok) add_random_token();
      send_text($urandom_range(0, 5) != 0);
      if ($urandom_range(0, 9) == 0) wait_tokens_drained();
    end
  endtask

  // raw bytes of any value, end_of_text now and then
  task automatic test_noise_bytes(input int n_items);
    repeat (n_items) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  // no input gaps and no output stalls; bytes that cause several tokens still stall
  task automatic test_back_to_back(input int n_items);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    test_random_text(n_items);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_integer_overflow();
    test_long_symbol();
    test_char_literals();
    test_random_text(90);
    wait_tokens_drained();
    test_noise_bytes(40);
    test_back_to_back(40);
    test_random_text(80);
    wait_tokens_drained();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sexpr_token_scanner.f
+incdir+hw/rtl
hw/rtl/sts_pkg.sv
hw/rtl/sts_scan.sv
hw/rtl/sts_token_buf.sv
hw/rtl/sexpr_token_scanner.sv
tb/sexpr_token_scanner_tb.sv
